// File: hdl/rmq_pkg.sv
// rmq_pkg: shared types and constants of the rotation matrix to quaternion pipeline
// used by rmq_sqrt, rmq_div and rotation_matrix_to_quaternion; no dependencies
package rmq_pkg;

	// which branch of the conversion produced the quaternion
	typedef enum logic [1:0] {
		BR_W = 2'd0,
		BR_X = 2'd1,
		BR_Y = 2'd2,
		BR_Z = 2'd3
	} branch_t;

	localparam int LANES = 3;
	localparam int NUM_W = 16;

	localparam logic [15:0] SAT_MAX = 16'h7fff;
	localparam logic [15:0] SAT_MIN = 16'h8000;

	// request as it travels through the square root stages
	typedef struct packed {
		branch_t                      code;
		logic [LANES-1:0]             neg;
		logic [LANES-1:0][NUM_W-1:0]  mag;
	} item_t;

	// request as it travels through the divider stages
	typedef struct packed {
		branch_t          code;
		logic [LANES-1:0] neg;
		logic [15:0]      rootq;
	} meta_t;

endpackage

// File: hdl/rmq_sqrt.sv
// rmq_sqrt: pipelined integer square root, one result bit per stage
// depends on rmq_pkg for the request payload type
module rmq_sqrt #(
	parameter int RW = 34
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [RW-1:0]         rad,
	input  rmq_pkg::item_t        item_in,
	output logic                  out_valid,
	output logic [RW/2-1:0]       root,
	output rmq_pkg::item_t        item_out
);

	localparam int HW = RW / 2;

	logic                 v_s    [HW];
	logic [HW+1:0]        rem_s  [HW];
	logic [HW-1:0]        root_s [HW];
	logic [RW-1:0]        rad_s  [HW];
	rmq_pkg::item_t       item_s [HW];

	logic                 cur_v    [HW];
	logic [HW+1:0]        cur_rem  [HW];
	logic [HW-1:0]        cur_root [HW];
	logic [RW-1:0]        cur_rad  [HW];
	rmq_pkg::item_t       cur_item [HW];

	logic [HW+1:0]        nxt_rem  [HW];
	logic [HW-1:0]        nxt_root [HW];

	always_comb begin
		logic [HW+1:0] r2;
		logic [HW+1:0] trial;
		logic          ge;
		cur_v[0]    = in_valid;
		cur_rem[0]  = '0;
		cur_root[0] = '0;
		cur_rad[0]  = rad;
		cur_item[0] = item_in;
		for (int j = 1; j < HW; j++) begin
			cur_v[j]    = v_s[j-1];
			cur_rem[j]  = rem_s[j-1];
			cur_root[j] = root_s[j-1];
			cur_rad[j]  = rad_s[j-1];
			cur_item[j] = item_s[j-1];
		end
		for (int j = 0; j < HW; j++) begin
			// bring down the next two radicand bits and try root*4+1
			r2          = {cur_rem[j][HW-1:0], cur_rad[j][RW-1 -: 2]};
			trial       = {cur_root[j], 2'b01};
			ge          = (r2 >= trial);
			nxt_rem[j]  = ge ? (r2 - trial) : r2;
			nxt_root[j] = {cur_root[j][HW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < HW; j++) v_s[j] <= 1'b0;
		end else if (en) begin
			for (int j = 0; j < HW; j++) v_s[j] <= cur_v[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < HW; j++) begin
				rem_s[j]  <= nxt_rem[j];
				root_s[j] <= nxt_root[j];
				rad_s[j]  <= cur_rad[j] << 2;
				item_s[j] <= cur_item[j];
			end
		end
	end

	assign out_valid = v_s[HW-1];
	assign root      = root_s[HW-1];
	assign item_out  = item_s[HW-1];

endmodule

// File: hdl/rmq_div.sv
// rmq_div: three-lane pipelined restoring divider, magnitude * 2^FB / den, saturated
// depends on rmq_pkg for payload types and saturation limits
module rmq_div #(
	parameter int DW = 19,
	parameter int FB = 14
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            en,
	input  logic                                            in_valid,
	input  logic [DW-1:0]                                   den,
	input  logic [rmq_pkg::LANES-1:0][rmq_pkg::NUM_W-1:0]   mag,
	input  rmq_pkg::meta_t                                  meta_in,
	output logic                                            out_valid,
	output logic [rmq_pkg::LANES-1:0][15:0]                 quot,
	output rmq_pkg::meta_t                                  meta_out
);

	localparam int QB = 17;
	localparam int NS = QB + 1;
	localparam int AW = rmq_pkg::NUM_W + FB;
	localparam int XW = ((AW > DW + QB) ? AW : DW + QB) + 1;
	localparam int L  = rmq_pkg::LANES;

	logic                 v_s    [NS];
	logic [XW-1:0]        rem_s  [NS][L];
	logic [QB-1:0]        q_s    [NS][L];
	logic [L-1:0]         ovf_s  [NS];
	logic [DW-1:0]        den_s  [NS];
	rmq_pkg::meta_t       meta_s [NS];

	logic                 cur_v    [NS];
	logic [XW-1:0]        cur_rem  [NS][L];
	logic [QB-1:0]        cur_q    [NS][L];
	logic [L-1:0]         cur_ovf  [NS];
	logic [DW-1:0]        cur_den  [NS];
	rmq_pkg::meta_t       cur_meta [NS];

	logic [XW-1:0]        nxt_rem  [NS][L];
	logic [QB-1:0]        nxt_q    [NS][L];
	logic [L-1:0]         nxt_ovf  [NS];

	always_comb begin
		logic [XW-1:0] trial;
		logic          ge;
		int            sh;
		cur_v[0]    = in_valid;
		cur_den[0]  = den;
		cur_meta[0] = meta_in;
		cur_ovf[0]  = '0;
		for (int l = 0; l < L; l++) begin
			cur_rem[0][l] = XW'(mag[l]) << FB;
			cur_q[0][l]   = '0;
		end
		for (int j = 1; j < NS; j++) begin
			cur_v[j]    = v_s[j-1];
			cur_den[j]  = den_s[j-1];
			cur_meta[j] = meta_s[j-1];
			cur_ovf[j]  = ovf_s[j-1];
			for (int l = 0; l < L; l++) begin
				cur_rem[j][l] = rem_s[j-1][l];
				cur_q[j][l]   = q_s[j-1][l];
			end
		end
		for (int j = 0; j < NS; j++) begin
			// first stage only flags a quotient of 2^QB or more
			sh    = (j == 0) ? QB : QB - j;
			trial = XW'(cur_den[j]) << sh;
			nxt_ovf[j] = cur_ovf[j];
			for (int l = 0; l < L; l++) begin
				ge = (cur_rem[j][l] >= trial);
				if (j == 0) begin
					nxt_rem[j][l] = cur_rem[j][l];
					nxt_q[j][l]   = cur_q[j][l];
					nxt_ovf[j][l] = ge;
				end else begin
					nxt_rem[j][l] = ge ? (cur_rem[j][l] - trial) : cur_rem[j][l];
					nxt_q[j][l]   = cur_q[j][l] | (ge ? (QB'(1) << sh) : '0);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NS; j++) v_s[j] <= 1'b0;
		end else if (en) begin
			for (int j = 0; j < NS; j++) v_s[j] <= cur_v[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NS; j++) begin
				den_s[j]  <= cur_den[j];
				meta_s[j] <= cur_meta[j];
				ovf_s[j]  <= nxt_ovf[j];
				for (int l = 0; l < L; l++) begin
					rem_s[j][l] <= nxt_rem[j][l];
					q_s[j][l]   <= nxt_q[j][l];
				end
			end
		end
	end

	// sign and saturate; a zero divisor gives zero
	always_comb begin
		logic [QB-1:0] m;
		logic          o;
		for (int l = 0; l < L; l++) begin
			m = q_s[NS-1][l];
			o = ovf_s[NS-1][l];
			if (den_s[NS-1] == '0) begin
				quot[l] = '0;
			end else if (meta_s[NS-1].neg[l]) begin
				quot[l] = (o || (m > QB'(32768))) ? rmq_pkg::SAT_MIN : 16'(~m + QB'(1));
			end else begin
				quot[l] = (o || (m > QB'(32767))) ? rmq_pkg::SAT_MAX : m[15:0];
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign meta_out  = meta_s[NS-1];

endmodule

// File: hdl/rotation_matrix_to_quaternion.sv
// rotation_matrix_to_quaternion: top level, 3x3 rotation matrix to unit quaternion
// depends on rmq_pkg, rmq_sqrt and rmq_div
//
// channel  dir  tdata / tuser                                     request ends
// s_*      in   tdata[143:0] m00 m01 m02 m10 m11 m12 m20 m21 m22   s_tvalid & s_tready
// m_*      out  tdata[63:0] quat_w quat_x quat_y quat_z            m_tvalid & m_tready
//               tuser[1:0] branch_case
//
// one request per cycle while s_tready is high; the registered stages are stage 1,
// the root stages (their number depends on FRAC_BITS), 18 divider stages, the final
// stage and the output register, a chain of valid-tagged stages that all advance together
// a one-entry skid buffer behind the output register holds a request when m_tready
// drops; s_tready is low only while that buffer is full
// arst_n clears valid bits and handshake state only
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,   // m00 m01 m02 m10 m11 m12 m20 m21 m22, 16 bits each
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // quat_w quat_x quat_y quat_z, 16 bits each
	output logic [1:0]   m_tuser    // branch_case
);

	localparam int F  = FRAC_BITS;
	// unsigned width of trace + one, with headroom
	localparam int SB = ((F > 17) ? F : 17) + 2;
	// radicand width, even, and root width
	localparam int RW = ((SB + F + 1) / 2) * 2;
	localparam int HW = RW / 2;
	// divisor width: 4 * floor(root / 2) or 2 * root
	localparam int DW = HW + 2;
	localparam int CW = (HW > 16) ? HW : 16;

	localparam longint ONE_L = longint'(1) << F;
	localparam logic signed [SB:0] ONE_S = (SB+1)'(ONE_L);
	// thresholds in integer form: s4*10000 > 4*one and t*1000 > 2*one
	localparam logic signed [SB:0] THR_W  = (SB+1)'((4 * ONE_L) / 10000);
	localparam logic signed [SB:0] THR_XY = (SB+1)'((2 * ONE_L) / 1000);
	localparam logic [15:0] Z_ONE = (F >= 15) ? rmq_pkg::SAT_MAX : 16'(ONE_L);

	logic en;
	logic out_v_q, skid_v_q;
	logic [63:0] out_data_q, skid_data_q;
	logic [1:0]  out_user_q, skid_user_q;

	// ------------------------------------------------------------------
	// stage 1: sums, branch choice, radicand and numerator selection
	// ------------------------------------------------------------------
	logic signed [15:0] m [9];
	logic signed [SB:0] s4, ty;
	logic signed [17:0] tx;
	logic signed [16:0] n [3];
	logic [RW-1:0]      rad;
	rmq_pkg::item_t     item;

	always_comb begin
		for (int i = 0; i < 9; i++) m[i] = $signed(s_tdata[16*i +: 16]);
		s4 = (SB+1)'(m[0]) + (SB+1)'(m[4]) + (SB+1)'(m[8]) + ONE_S;
		tx = -(18'(m[4]) + 18'(m[8]));
		ty = ONE_S - (SB+1)'(m[8]);
		n[0] = '0;
		n[1] = '0;
		n[2] = '0;
		rad  = '0;
		if (s4 > THR_W) begin
			item.code = rmq_pkg::BR_W;
			rad  = RW'(s4[SB-1:0]) << F;
			n[0] = 17'(m[5]) - 17'(m[7]);
			n[1] = 17'(m[6]) - 17'(m[2]);
			n[2] = 17'(m[1]) - 17'(m[3]);
		end else if ((SB+1)'(tx) > THR_XY) begin
			item.code = rmq_pkg::BR_X;
			rad  = RW'(tx[16:0]) << (F - 1);
			n[0] = 17'(m[1]);
			n[1] = 17'(m[2]);
		end else if (ty > THR_XY) begin
			item.code = rmq_pkg::BR_Y;
			rad  = RW'(ty[SB-1:0]) << (F - 1);
			n[0] = 17'(m[5]);
		end else begin
			item.code = rmq_pkg::BR_Z;
		end
		for (int l = 0; l < rmq_pkg::LANES; l++) begin
			item.neg[l] = n[l][16];
			item.mag[l] = n[l][16] ? 16'(-n[l]) : n[l][15:0];
		end
	end

	logic            v_s1;
	logic [RW-1:0]   rad_s1;
	rmq_pkg::item_t  item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1  <= rad;
			item_s1 <= item;
		end
	end

	// ------------------------------------------------------------------
	// square root stages
	// ------------------------------------------------------------------
	logic            sq_v;
	logic [HW-1:0]   sq_root;
	rmq_pkg::item_t  sq_item;

	rmq_sqrt #(
		.RW(RW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.rad      (rad_s1),
		.item_in  (item_s1),
		.out_valid(sq_v),
		.root     (sq_root),
		.item_out (sq_item)
	);

	// w path halves the root and divides by 4w, the others divide by 2 * root
	logic [HW-1:0]   comp;
	logic [DW-1:0]   den;
	rmq_pkg::meta_t  meta;

	always_comb begin
		if (sq_item.code == rmq_pkg::BR_W) begin
			comp = sq_root >> 1;
			den  = DW'(comp) << 2;
		end else begin
			comp = sq_root;
			den  = DW'(comp) << 1;
		end
		meta.code  = sq_item.code;
		meta.neg   = sq_item.neg;
		meta.rootq = (CW'(comp) > CW'(32767)) ? rmq_pkg::SAT_MAX : 16'(comp);
	end

	// ------------------------------------------------------------------
	// divider stages
	// ------------------------------------------------------------------
	logic                                       dv_v;
	logic [rmq_pkg::LANES-1:0][15:0]            dv_q;
	rmq_pkg::meta_t                             dv_meta;

	rmq_div #(
		.DW(DW),
		.FB(F)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_v),
		.den      (den),
		.mag      (sq_item.mag),
		.meta_in  (meta),
		.out_valid(dv_v),
		.quot     (dv_q),
		.meta_out (dv_meta)
	);

	// ------------------------------------------------------------------
	// final stage: place components by branch
	// ------------------------------------------------------------------
	logic [15:0] qw, qx, qy, qz;

	always_comb begin
		qw = '0;
		qx = '0;
		qy = '0;
		qz = '0;
		case (dv_meta.code)
			rmq_pkg::BR_W: begin
				qw = dv_meta.rootq;
				qx = dv_q[0];
				qy = dv_q[1];
				qz = dv_q[2];
			end
			rmq_pkg::BR_X: begin
				qx = dv_meta.rootq;
				qy = dv_q[0];
				qz = dv_q[1];
			end
			rmq_pkg::BR_Y: begin
				qy = dv_meta.rootq;
				qz = dv_q[0];
			end
			default: begin
				qz = Z_ONE;
			end
		endcase
	end

	logic        v_fin_s;
	logic [63:0] data_fin_s;
	logic [1:0]  user_fin_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_fin_s <= 1'b0;
		end else if (en) begin
			v_fin_s <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_fin_s <= {qz, qy, qx, qw};
			user_fin_s <= dv_meta.code;
		end
	end

	// ------------------------------------------------------------------
	// output register with one-entry skid buffer
	// ------------------------------------------------------------------
	logic pop, leaving;

	assign en      = !skid_v_q;
	assign pop     = out_v_q && m_tready;
	assign leaving = en && v_fin_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (leaving) begin
			if (!out_v_q || pop) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
				out_user_q <= skid_user_q;
			end
		end else if (leaving) begin
			if (!out_v_q || pop) begin
				out_data_q <= data_fin_s;
				out_user_q <= user_fin_s;
			end else begin
				skid_data_q <= data_fin_s;
				skid_user_q <= user_fin_s;
			end
		end
	end

	assign s_tready = en;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

`ifndef SYNTHESIS
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid buffer holds a request while output register is empty");

	a_skid_held: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !m_tready |=> skid_v_q)
		else $error("skid request dropped without a handshake");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_tready))
		else $error("skid buffer filled while output was free");

	a_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && (out_user_q == rmq_pkg::BR_Z) |->
			(out_data_q[47:0] == 48'd0) && (out_data_q[63:48] == Z_ONE))
		else $error("fallback quaternion is not (0, 0, 0, one)");

	a_w_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && (out_user_q != rmq_pkg::BR_W) |-> (out_data_q[15:0] == 16'd0))
		else $error("w is nonzero outside the w path");
`endif

endmodule
